/* design/dld_pkg.sv */
package dld_pkg;

    // Width of the length fields in the result channel.
    localparam int LEN_W = 6;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Operand select carried by the command field.
    localparam logic CMD_DIVIDEND = 1'b0;
    localparam logic CMD_DIVISOR  = 1'b1;

    typedef struct packed {
        logic       command;
        logic [3:0] digit;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]       quotient_digit;
        logic [3:0]       remainder_digit;
        logic [LEN_W-1:0] quotient_length;
        logic [LEN_W-1:0] remainder_length;
        logic [1:0]       status;
        logic             final_res;
    } out_beat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic check;
        logic c_ex;
        logic s_ex;
        logic f_ex;
        logic e_ld;
        logic e_next;
    } dld_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start;
        logic err;
        logic short_div;
        logic i_at_k;
        logic brw;
        logic a_zero;
        logic i_at_end;
        logic out_final;
    } dld_sts_t;

endpackage

/* design/dld_ram.sv */
module dld_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* design/dld_ctrl.sv */
module dld_ctrl import dld_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     out_ready,
    input  dld_sts_t sts,
    output dld_cmd_t cmd,
    output logic     in_ready,
    output logic     out_valid
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_C_RD   = 4'd2;
    localparam logic [3:0] S_C_EX   = 4'd3;
    localparam logic [3:0] S_S_RD   = 4'd4;
    localparam logic [3:0] S_S_EX   = 4'd5;
    localparam logic [3:0] S_F_RD   = 4'd6;
    localparam logic [3:0] S_F_EX   = 4'd7;
    localparam logic [3:0] S_E_RD   = 4'd8;
    localparam logic [3:0] S_E_LD   = 4'd9;
    localparam logic [3:0] S_E_WAIT = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Handshake and command decode.
    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        out_valid  = (state_reg == S_E_WAIT);
        cmd.load   = in_ready && in_valid;
        cmd.check  = (state_reg == S_CHECK);
        cmd.c_ex   = (state_reg == S_C_EX);
        cmd.s_ex   = (state_reg == S_S_EX);
        cmd.f_ex   = (state_reg == S_F_EX);
        cmd.e_ld   = (state_reg == S_E_LD);
        cmd.e_next = out_valid && out_ready && !sts.out_final;
    end

    // Sequencing of compare, subtract, scan and emit passes.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sts.start)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.err)
                    state_next = S_E_WAIT;
                else if (sts.short_div)
                    state_next = S_E_RD;
                else
                    state_next = S_C_RD;
            end
            S_C_RD:
                state_next = S_C_EX;
            S_C_EX:
            begin
                if (!sts.i_at_k)
                    state_next = S_C_RD;
                else if (!sts.brw)
                    state_next = S_S_RD;
                else if (sts.a_zero)
                    state_next = S_F_RD;
                else
                    state_next = S_C_RD;
            end
            S_S_RD:
                state_next = S_S_EX;
            S_S_EX:
                state_next = sts.i_at_k ? S_C_RD : S_S_RD;
            S_F_RD:
                state_next = S_F_EX;
            S_F_EX:
                state_next = sts.i_at_end ? S_E_RD : S_F_RD;
            S_E_RD:
                state_next = S_E_LD;
            S_E_LD:
                state_next = S_E_WAIT;
            S_E_WAIT:
            begin
                if (out_ready)
                    state_next = sts.out_final ? S_IDLE : S_E_RD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* design/dld_datapath.sv */
module dld_datapath import dld_pkg::*; #(
    parameter int MAX_DIGITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  in_beat_t  in_data,
    input  dld_cmd_t  cmd,
    output dld_sts_t  sts,
    output out_beat_t out_data
);

    localparam int LW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);

    // Operand load bookkeeping.
    logic [LW-1:0] dl_reg, dnz_reg, vl_reg, vnz_reg;
    logic          ovf_reg;
    // Division working registers.
    logic [LW-1:0] n_reg, k_reg, a_reg, i_reg, qlen_reg, rlen_reg;
    logic          empty_reg, zero_reg, eovf_reg, brw_reg, qzero_reg;
    logic [3:0]    qcnt_reg;
    out_beat_t     out_reg;

    logic [LW-1:0] len_sel, nz_sel, len_inc, nz_new, len_new, win, cnt;
    logic          full;
    logic [3:0]    dig, r_rd, d_rd, q_rd, r_dig, d_dig, diff_dig, qd, rd;
    logic [4:0]    tmp5;
    logic          brw_next;

    // Next length and highest nonzero position of the operand being loaded.
    always_comb
    begin
        len_sel = (in_data.command == CMD_DIVISOR) ? vl_reg : dl_reg;
        nz_sel  = (in_data.command == CMD_DIVISOR) ? vnz_reg : dnz_reg;
        full    = (len_sel == LW'(MAX_DIGITS));
        dig     = (in_data.digit > 4'd9) ? 4'd9 : in_data.digit;
        len_inc = LW'(len_sel + 1'b1);
        nz_new  = (!full && dig != 4'd0) ? len_inc : nz_sel;
        if (in_data.last)
            len_new = (nz_new == '0) ? LW'(1) : nz_new;
        else
            len_new = full ? len_sel : len_inc;
    end

    // One digit step of the trial subtraction, masked outside each operand, and the masked result digits.
    always_comb
    begin
        win      = LW'(a_reg + i_reg);
        r_dig    = (empty_reg || win >= n_reg) ? 4'd0 : r_rd;
        d_dig    = (i_reg >= k_reg) ? 4'd0 : d_rd;
        tmp5     = {1'b0, r_dig} - {1'b0, d_dig} - {4'd0, brw_reg};
        brw_next = tmp5[4];
        diff_dig = brw_next ? 4'(tmp5 + 5'd10) : tmp5[3:0];
        cnt      = (qlen_reg > rlen_reg) ? qlen_reg : rlen_reg;
        qd       = (qzero_reg || i_reg >= qlen_reg) ? 4'd0 : q_rd;
        rd       = (empty_reg || i_reg >= rlen_reg) ? 4'd0 : r_rd;
    end

    // Status toward the controller.
    always_comb
    begin
        sts.start     = cmd.load && (in_data.command == CMD_DIVISOR) && in_data.last;
        sts.err       = eovf_reg || zero_reg;
        sts.short_div = (n_reg < k_reg);
        sts.i_at_k    = (i_reg == k_reg);
        sts.brw       = brw_next;
        sts.a_zero    = (a_reg == '0);
        sts.i_at_end  = (LW'(i_reg + 1'b1) == n_reg);
        sts.out_final = out_reg.final_res;
    end

    assign out_data = out_reg;

    // Digit stores.
    dld_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_rem (
        .clk     (clk),
        .wr_en   ((cmd.load && in_data.command == CMD_DIVIDEND && !full)
                  || (cmd.s_ex && win < n_reg)),
        .wr_addr (cmd.load ? dl_reg[AW-1:0] : win[AW-1:0]),
        .wr_data (cmd.load ? dig : diff_dig),
        .rd_addr (win[AW-1:0]),
        .rd_data (r_rd)
    );

    dld_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_dvs (
        .clk     (clk),
        .wr_en   (cmd.load && in_data.command == CMD_DIVISOR && !full),
        .wr_addr (vl_reg[AW-1:0]),
        .wr_data (dig),
        .rd_addr (i_reg[AW-1:0]),
        .rd_data (d_rd)
    );

    dld_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_quo (
        .clk     (clk),
        .wr_en   (cmd.c_ex && sts.i_at_k && brw_next),
        .wr_addr (a_reg[AW-1:0]),
        .wr_data (qcnt_reg),
        .rd_addr (win[AW-1:0]),
        .rd_data (q_rd)
    );

    // Operand lengths; the division start clears them for the next operands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_reg  <= '0;
            dnz_reg <= '0;
            vl_reg  <= '0;
            vnz_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (sts.start)
        begin
            dl_reg  <= '0;
            dnz_reg <= '0;
            vl_reg  <= '0;
            vnz_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            ovf_reg <= ovf_reg || full;
            if (in_data.command == CMD_DIVISOR)
            begin
                vl_reg  <= len_new;
                vnz_reg <= nz_new;
            end
            else
            begin
                dl_reg  <= len_new;
                dnz_reg <= nz_new;
            end
        end
    end

    // Long division counters and the result register.
    always_ff @(posedge clk)
    begin
        if (sts.start)
        begin
            n_reg     <= (dnz_reg == '0) ? LW'(1) : dnz_reg;
            empty_reg <= (dl_reg == '0);
            k_reg     <= (nz_new == '0) ? LW'(1) : nz_new;
            zero_reg  <= (nz_new == '0);
            eovf_reg  <= ovf_reg || full;
        end
        if (cmd.check)
        begin
            i_reg     <= '0;
            brw_reg   <= 1'b0;
            qcnt_reg  <= 4'd0;
            a_reg     <= sts.short_div ? '0 : LW'(n_reg - k_reg);
            qlen_reg  <= LW'(1);
            qzero_reg <= sts.short_div;
            rlen_reg  <= n_reg;
            out_reg   <= '{quotient_digit: 4'd0, remainder_digit: 4'd0,
                           quotient_length: LEN_W'(1), remainder_length: LEN_W'(1),
                           status: eovf_reg ? ST_OVERFLOW : ST_DIV_ZERO,
                           final_res: 1'b1};
        end
        if (cmd.c_ex)
        begin
            if (!sts.i_at_k)
            begin
                i_reg   <= LW'(i_reg + 1'b1);
                brw_reg <= brw_next;
            end
            else if (!brw_next)
            begin
                qcnt_reg <= qcnt_reg + 4'd1;
                i_reg    <= '0;
                brw_reg  <= 1'b0;
            end
            else
            begin
                // Position done: the first nonzero quotient digit sets the length.
                if (qcnt_reg != 4'd0 && LW'(a_reg + 1'b1) > qlen_reg)
                    qlen_reg <= LW'(a_reg + 1'b1);
                i_reg    <= '0;
                brw_reg  <= 1'b0;
                qcnt_reg <= 4'd0;
                if (sts.a_zero)
                    rlen_reg <= LW'(1);
                else
                    a_reg <= LW'(a_reg - 1'b1);
            end
        end
        if (cmd.s_ex)
        begin
            if (!sts.i_at_k)
            begin
                i_reg   <= LW'(i_reg + 1'b1);
                brw_reg <= brw_next;
            end
            else
            begin
                i_reg   <= '0;
                brw_reg <= 1'b0;
            end
        end
        // Remainder length scan, lowest digit upward.
        if (cmd.f_ex)
        begin
            if (r_dig != 4'd0)
                rlen_reg <= LW'(i_reg + 1'b1);
            i_reg <= sts.i_at_end ? '0 : LW'(i_reg + 1'b1);
        end
        if (cmd.e_ld)
        begin
            out_reg <= '{quotient_digit: qd, remainder_digit: rd,
                         quotient_length: LEN_W'(qlen_reg),
                         remainder_length: LEN_W'(rlen_reg),
                         status: ST_OK,
                         final_res: (LW'(i_reg + 1'b1) == cnt)};
        end
        if (cmd.e_next)
            i_reg <= LW'(i_reg + 1'b1);
    end

endmodule

/* design/decimal_long_divider_unit.sv */
// Loading accepts one digit beat per cycle while idle; the divisor beat with last set starts division.
// Division: per quotient position, up to ten compare passes and nine subtract passes,
// each stepping over the divisor digits through the registered read ports; then a remainder scan.
// Results leave one beat at a time, each read, loaded and held until out_ready; an error result is one beat.
// Reset clears the controller and the operand lengths; the digit stores are not cleared.
module decimal_long_divider_unit import dld_pkg::*; #(
    parameter int MAX_DIGITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    dld_cmd_t cmd;
    dld_sts_t sts;

    dld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    dld_datapath #(.MAX_DIGITS(MAX_DIGITS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

    // No input beat is taken while a result beat is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    // Error results are always the final beat of a division.
    a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ST_OK) |-> out_data.final_res)
        else $error("error result not marked final");

    // Emitted digits are decimal.
    a_digits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.quotient_digit <= 4'd9 && out_data.remainder_digit <= 4'd9))
        else $error("result digit out of range");

    // A loaded result beat is presented on the next cycle.
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.e_ld |=> out_valid)
        else $error("result beat not presented");

endmodule

/* tb/sv/decimal_long_divider_unit_test.sv */
module decimal_long_divider_unit_test;
    import dld_pkg::*;

    localparam int NDIG = 32;
    localparam int WATCHDOG_LIMIT = 200000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    decimal_long_divider_unit #(.MAX_DIGITS(NDIG)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    // Predictor state: operand digits and their lengths.
    int        dvd_digits[NDIG];
    int        dvs_digits[NDIG];
    int        dvd_len;
    int        dvs_len;
    bit        capacity_hit;

    in_beat_t  pending_beats[$];
    out_beat_t expected_beats[$];
    int        mismatch_count;
    bit        calm_phase;
    bit        long_hold;
    int        quiet_cycles;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int trimmed(ref int d[NDIG], input int len);
        while (len > 1 && d[len-1] == 0)
            len--;
        return len;
    endfunction

    // Compare two little-endian digit arrays of given lengths: 1 if a >= b.
    function automatic bit not_less(int a[], int alen, int b[], int blen);
        if (alen != blen)
            return alen > blen;
        for (int i = alen - 1; i >= 0; i--)
            if (a[i] != b[i])
                return a[i] > b[i];
        return 1'b1;
    endfunction

    function automatic void push_error(logic [1:0] st);
        out_beat_t r;
        r.quotient_digit = 4'd0;
        r.remainder_digit = 4'd0;
        r.quotient_length = 6'd1;
        r.remainder_length = 6'd1;
        r.status = st;
        r.final_res = 1'b1;
        expected_beats.push_back(r);
    endfunction

    // Long division of the held operands; queues the expected result beats.
    function automatic void predict_quotient();
        int n, k, qlen, rlen, cnt;
        int rem[];
        int dv[];
        int quo[];
        int shifted[];
        out_beat_t r;
        n = dvd_len;
        k = dvs_len;
        dvd_len = 0;
        dvs_len = 0;
        if (capacity_hit)
        begin
            capacity_hit = 1'b0;
            push_error(ST_OVERFLOW);
            return;
        end
        if (k == 0 || (k == 1 && dvs_digits[0] == 0))
        begin
            push_error(ST_DIV_ZERO);
            return;
        end
        if (n == 0)
        begin
            dvd_digits[0] = 0;
            n = 1;
        end
        n = trimmed(dvd_digits, n);
        k = trimmed(dvs_digits, k);
        rem = new[n];
        for (int i = 0; i < n; i++)
            rem[i] = dvd_digits[i];
        dv = new[k];
        for (int i = 0; i < k; i++)
            dv[i] = dvs_digits[i];
        rlen = n;
        if (n < k)
        begin
            quo = new[1];
            quo[0] = 0;
            qlen = 1;
        end
        else
        begin
            quo = new[n - k + 1];
            for (int a = n - k; a >= 0; a--)
            begin
                quo[a] = 0;
                // Repeated subtraction of divisor shifted by a positions.
                forever
                begin
                    shifted = new[rlen - a > 0 ? rlen - a : 1];
                    for (int i = 0; i < rlen - a; i++)
                        shifted[i] = rem[a + i];
                    if (rlen - a <= 0 || !not_less(shifted, rlen - a, dv, k))
                        break;
                    begin
                        int borrow;
                        int v;
                        borrow = 0;
                        for (int i = 0; a + i < rlen; i++)
                        begin
                            v = rem[a + i] - (i < k ? dv[i] : 0) - borrow;
                            borrow = v < 0;
                            rem[a + i] = v < 0 ? v + 10 : v;
                        end
                    end
                    while (rlen > 1 && rem[rlen-1] == 0)
                        rlen--;
                    quo[a]++;
                end
            end
            qlen = n - k + 1;
            while (qlen > 1 && quo[qlen-1] == 0)
                qlen--;
        end
        cnt = qlen > rlen ? qlen : rlen;
        for (int i = 0; i < cnt; i++)
        begin
            r.quotient_digit = i < qlen ? 4'(quo[i]) : 4'd0;
            r.remainder_digit = i < rlen ? 4'(rem[i]) : 4'd0;
            r.quotient_length = 6'(qlen);
            r.remainder_length = 6'(rlen);
            r.status = ST_OK;
            r.final_res = (i + 1 == cnt);
            expected_beats.push_back(r);
        end
    endfunction

    // Apply one accepted beat to the predictor.
    function automatic void absorb_beat(in_beat_t b);
        int dg;
        dg = b.digit > 9 ? 9 : int'(b.digit);
        if (b.command == CMD_DIVIDEND)
        begin
            if (dvd_len < NDIG)
                dvd_digits[dvd_len++] = dg;
            else
                capacity_hit = 1'b1;
            if (b.last && dvd_len > 0)
                dvd_len = trimmed(dvd_digits, dvd_len);
        end
        else
        begin
            if (dvs_len < NDIG)
                dvs_digits[dvs_len++] = dg;
            else
                capacity_hit = 1'b1;
            if (b.last && dvs_len > 0)
                dvs_len = trimmed(dvs_digits, dvs_len);
            if (b.last)
                predict_quotient();
        end
    endfunction

    function automatic in_beat_t mk(logic cmd, logic [3:0] dg, logic lst);
        in_beat_t b;
        b.command = cmd;
        b.digit = dg;
        b.last = lst;
        return b;
    endfunction

    // Queue an operand of the given length; digits 0..9, some 10..15 with wide_digits; zero_top zeroes the top two.
    task automatic queue_operand(logic cmd, int len, bit wide_digits, bit zero_top);
        logic [3:0] dg;
        for (int i = 0; i < len; i++)
        begin
            dg = wide_digits && $urandom_range(0, 9) == 0 ? 4'($urandom_range(10, 15))
                                                           : 4'($urandom_range(0, 9));
            if (zero_top && i >= len - 2)
                dg = 4'd0;
            pending_beats.push_back(mk(cmd, dg, i == len - 1));
        end
    endtask

    // The in_ready_q register holds whether the last offered beat was taken;
    // the driver keeps valid and payload steady until then.
    logic in_ready_q;

    // Driver: offers queued beats with random idle bursts.
    int in_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else if (!(in_valid && !in_ready_q))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                in_data <= pending_beats.pop_front();
                in_valid <= 1'b1;
                if (!calm_phase && $urandom_range(0, 7) == 0)
                    in_gap = $urandom_range(1, 17);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Acceptance flag sampled at the rising edge.
    always @(posedge clk)
        in_ready_q <= in_valid && in_ready ? 1'b1 : 1'b0;

    // Receiver readiness: random bursts of stall plus one long hold-off.
    int out_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap = 0;
        end
        else if (long_hold)
            out_ready <= 1'b0;
        else if (out_gap > 0)
        begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm_phase && $urandom_range(0, 5) == 0)
                out_gap = $urandom_range(1, 17);
        end
    end

    // Long receiver hold-off early in the run, counted here.
    initial
    begin
        long_hold = 1'b0;
        @(posedge rst_n);
        long_hold = 1'b1;
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
    end

    // Input monitor feeds the predictor.
    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
            absorb_beat(in_data);

    // Output monitor compares against the oldest expectation.
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat %p", out_data);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (out_data !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %p, got %p", want, out_data);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** decimal_long_divider_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int kind;
        int la;
        int lb;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        in_ready_q = 1'b0;
        dvd_len = 0;
        dvs_len = 0;
        capacity_hit = 1'b0;
        mismatch_count = 0;
        calm_phase = 1'b0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: 99 / 9, divide by zero, short dividend, empty dividend,
        // digit above nine, trailing zeros, appended dividend digits.
        pending_beats.push_back(mk(CMD_DIVIDEND, 4'd9, 1'b0));
        pending_beats.push_back(mk(CMD_DIVIDEND, 4'd9, 1'b1));
        pending_beats.push_back(mk(CMD_DIVISOR, 4'd9, 1'b1));
        pending_beats.push_back(mk(CMD_DIVIDEND, 4'd5, 1'b1));
        pending_beats.push_back(mk(CMD_DIVISOR, 4'd0, 1'b0));
        pending_beats.push_back(mk(CMD_DIVISOR, 4'd0, 1'b1));
        pending_beats.push_back(mk(CMD_DIVIDEND, 4'd7, 1'b1));
        pending_beats.push_back(mk(CMD_DIVISOR, 4'd3, 1'b0));
        pending_beats.push_back(mk(CMD_DIVISOR, 4'd1, 1'b1));
        pending_beats.push_back(mk(CMD_DIVISOR, 4'd15, 1'b1));
        pending_beats.push_back(mk(CMD_DIVIDEND, 4'd12, 1'b0));
        pending_beats.push_back(mk(CMD_DIVIDEND, 4'd0, 1'b1));
        pending_beats.push_back(mk(CMD_DIVIDEND, 4'd4, 1'b1));
        pending_beats.push_back(mk(CMD_DIVISOR, 4'd1, 1'b1));
        // Full-width dividend divided by one, then a store overflow.
        queue_operand(CMD_DIVIDEND, NDIG, 1'b0, 1'b0);
        pending_beats.push_back(mk(CMD_DIVISOR, 4'd1, 1'b1));
        queue_operand(CMD_DIVIDEND, NDIG + 1, 1'b0, 1'b0);
        pending_beats.push_back(mk(CMD_DIVISOR, 4'd2, 1'b1));

        // Long receiver hold-off while the sender keeps offering divisions.
        for (int i = 0; i < 4; i++)
        begin
            queue_operand(CMD_DIVIDEND, 3, 1'b0, 1'b0);
            queue_operand(CMD_DIVISOR, 1, 1'b0, 1'b0);
        end

        // Random divisions, mostly small, a few full width.
        while (pending_beats.size() > 0 || expected_beats.size() > 0)
            @(posedge clk);
        for (int t = 0; t < 22; t++)
        begin
            if (t == 18)
                calm_phase = 1'b1;
            kind = $urandom_range(0, 19);
            la = kind == 0 ? NDIG : $urandom_range(0, 6);
            lb = kind == 1 ? $urandom_range(NDIG - 2, NDIG) : $urandom_range(1, 4);
            if (kind == 2)
                la = NDIG + $urandom_range(1, 2);
            if (la > 0)
                queue_operand(CMD_DIVIDEND, la, 1'b1, $urandom_range(0, 4) == 0);
            queue_operand(CMD_DIVISOR, lb, 1'b1, $urandom_range(0, 5) == 0);
            while (pending_beats.size() > 8)
                @(posedge clk);
        end

        while (pending_beats.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_beats.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("** decimal_long_divider_unit: PASSED **");
        else
            $display("** decimal_long_divider_unit: FAILED **");
        $finish;
    end

endmodule
